/* rtl/cfr_pkg.sv */
// ----------------------------------------------------------------------------
// cfr_pkg
// Shared sizes and constants for the COBS / Fletcher-16 frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package cfr_pkg;

  localparam int unsigned MAX_PAYLOAD   = 32;
  localparam int unsigned ENCODED_DEPTH = 40;
  localparam int unsigned DEC_DEPTH     = MAX_PAYLOAD + 3;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned TOTAL_W = 32;

  localparam int unsigned ENC_IDX_W = $clog2(ENCODED_DEPTH);
  localparam int unsigned ENC_CNT_W = $clog2(ENCODED_DEPTH + 1);
  localparam int unsigned DEC_IDX_W = $clog2(DEC_DEPTH);
  localparam int unsigned DEC_CNT_W = $clog2(DEC_DEPTH + 1);

  // smallest frame: type byte plus two check bytes
  localparam int unsigned CHK_MIN      = 3;
  localparam int unsigned FLETCHER_MOD = 255;

  // code byte that ends a block without an implied zero
  localparam logic [BYTE_W-1:0] CODE_NO_ZERO = 8'hFF;

  typedef logic [BYTE_W-1:0]  byte_t;
  typedef logic [TOTAL_W-1:0] total_t;

endpackage

`default_nettype wire

/* rtl/cfr_if.sv */
// ----------------------------------------------------------------------------
// cfr_in_if / cfr_out_if
// Valid/ready channels for link bytes in and decoded results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface cfr_in_if
  import cfr_pkg::*;
;
  logic  valid;
  logic  ready;
  byte_t in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface cfr_out_if
  import cfr_pkg::*;
;
  logic   valid;
  logic   ready;
  logic   status;
  byte_t  out_byte;
  logic   is_type;
  logic   last;
  total_t discard_total;

  modport source (output valid, output status, output out_byte, output is_type,
                  output last, output discard_total, input ready);
  modport sink   (input valid, input status, input out_byte, input is_type,
                  input last, input discard_total, output ready);
endinterface

`default_nettype wire

/* rtl/cobs_fletcher_frame_receiver_unit.sv */
// ----------------------------------------------------------------------------
// cobs_fletcher_frame_receiver_unit
// COBS frame receiver with Fletcher-16 check and discard counter.
// ----------------------------------------------------------------------------
// in_i carries one encoded link byte per transaction. A non-zero byte is
// stored and in_i stays ready. A zero byte closes the frame: the stored bytes
// are walked through one shared decode and checksum datapath, each encoded
// byte through a fetch and a decode state and each implied zero through a
// zero state, with the encoded buffer's single read port setting that pace.
// A good frame then leaves on out_o as the type byte followed by the payload
// bytes, each read from the decoded buffer, then loaded, with last on the
// final one. An overrun, malformed, oversize, short or bad-checksum frame
// gives one discard result carrying the updated 32-bit discard count. An
// empty frame gives nothing. in_i is not ready from a delimiter until its
// last result is loaded into the output register; a stalled out_o holds that
// register and the sequencer waits. Reset empties the encoded buffer, clears
// the overrun flag and the discard count; the buffers need no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module cobs_fletcher_frame_receiver_unit
  import cfr_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  cfr_in_if.sink     in_i,
  cfr_out_if.source  out_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FETCH = 3'd1;
  localparam logic [2:0] S_DEC   = 3'd2;
  localparam logic [2:0] S_ZERO  = 3'd3;
  localparam logic [2:0] S_CHECK = 3'd4;
  localparam logic [2:0] S_ORD   = 3'd5;
  localparam logic [2:0] S_OWAIT = 3'd6;
  localparam logic [2:0] S_DISC  = 3'd7;

  function automatic byte_t add_mod(input byte_t a, input byte_t b);
    logic [BYTE_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (BYTE_W+1)'(FLETCHER_MOD)) s = s - (BYTE_W+1)'(FLETCHER_MOD);
    return s[BYTE_W-1:0];
  endfunction

  logic [2:0]           state_q, state_d;
  logic [ENC_CNT_W-1:0] cnt_q, cnt_d;
  logic                 ovr_q, ovr_d;
  logic [ENC_CNT_W-1:0] len_q, len_d;
  logic [ENC_CNT_W-1:0] rd_q, rd_d;
  logic [DEC_CNT_W-1:0] wr_q, wr_d;
  logic [DEC_CNT_W-1:0] oi_q, oi_d;
  byte_t                rem_q, rem_d;
  logic                 ff_q, ff_d;
  byte_t                lo_q, lo_d, hi_q, hi_d;
  byte_t                h0_q, h0_d, h1_q, h1_d;
  total_t               disc_q, disc_d;

  logic                 out_valid_q, out_valid_d;
  logic                 out_load;
  logic                 out_status_q, out_status_d;
  byte_t                out_byte_q, out_byte_d;
  logic                 out_type_q, out_type_d;
  logic                 out_last_q, out_last_d;
  total_t               out_total_q, out_total_d;

  byte_t                enc_mem [ENCODED_DEPTH];
  byte_t                dec_mem [DEC_DEPTH];
  byte_t                enc_rd_q, dec_rd_q;
  logic                 enc_we;
  logic                 emit_en;
  byte_t                emit_val;

  byte_t                lo_sum;
  byte_t                rem_n;
  logic                 ff_n;
  logic [ENC_CNT_W-1:0] rd_n;
  logic                 dec_full;
  logic                 out_free;
  logic                 run_last;
  logic                 sum_ok;

  assign in_i.ready = (state_q == S_IDLE);
  assign out_free   = !out_valid_q || out_o.ready;
  assign dec_full   = (wr_q >= DEC_CNT_W'(DEC_DEPTH));
  assign lo_sum     = add_mod(lo_q, h0_q);
  assign run_last   = ((oi_q + DEC_CNT_W'(CHK_MIN)) == wr_q);
  assign sum_ok     = (wr_q >= DEC_CNT_W'(CHK_MIN)) && (lo_q == h0_q) && (hi_q == h1_q);

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    ovr_d        = ovr_q;
    len_d        = len_q;
    rd_d         = rd_q;
    wr_d         = wr_q;
    oi_d         = oi_q;
    rem_d        = rem_q;
    ff_d         = ff_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    h0_d         = h0_q;
    h1_d         = h1_q;
    disc_d       = disc_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_load     = 1'b0;
    out_status_d = 1'b0;
    out_byte_d   = '0;
    out_type_d   = 1'b0;
    out_last_d   = 1'b0;
    out_total_d  = disc_q;
    enc_we       = 1'b0;
    emit_en      = 1'b0;
    emit_val     = '0;
    rem_n        = '0;
    ff_n         = 1'b0;
    rd_n         = rd_q + ENC_CNT_W'(1);

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          if (in_i.in_byte != '0) begin
            if (cnt_q >= ENC_CNT_W'(ENCODED_DEPTH)) begin
              ovr_d = 1'b1;
            end else begin
              enc_we = 1'b1;
              cnt_d  = cnt_q + ENC_CNT_W'(1);
            end
          end else begin
            len_d = cnt_q;
            cnt_d = '0;
            ovr_d = 1'b0;
            if (ovr_q) begin
              state_d = S_DISC;
            end else if (cnt_q != '0) begin
              rd_d    = '0;
              wr_d    = '0;
              rem_d   = '0;
              ff_d    = 1'b0;
              lo_d    = '0;
              hi_d    = '0;
              state_d = S_FETCH;
            end
          end
        end
      end
      S_FETCH: begin
        state_d = S_DEC;
      end
      S_DEC: begin
        rd_d = rd_n;
        if (rem_q == '0) begin
          // code byte: count of data bytes that follow plus one
          rem_n = enc_rd_q - BYTE_W'(1);
          ff_n  = (enc_rd_q == CODE_NO_ZERO);
        end else begin
          rem_n    = rem_q - BYTE_W'(1);
          ff_n     = ff_q;
          emit_en  = !dec_full;
          emit_val = enc_rd_q;
        end
        rem_d = rem_n;
        ff_d  = ff_n;
        if (rem_q != '0 && dec_full) begin
          state_d = S_DISC;
        end else if (rem_n != '0) begin
          state_d = (rd_n >= len_q) ? S_DISC : S_FETCH;
        end else if (!ff_n && rd_n < len_q) begin
          state_d = S_ZERO;
        end else if (rd_n >= len_q) begin
          state_d = S_CHECK;
        end else begin
          state_d = S_FETCH;
        end
      end
      S_ZERO: begin
        if (dec_full) begin
          state_d = S_DISC;
        end else begin
          emit_en = 1'b1;
          state_d = S_FETCH;
        end
      end
      S_CHECK: begin
        oi_d    = '0;
        state_d = sum_ok ? S_ORD : S_DISC;
      end
      S_ORD: begin
        state_d = S_OWAIT;
      end
      S_OWAIT: begin
        if (out_free) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          out_byte_d  = dec_rd_q;
          out_type_d  = (oi_q == '0);
          out_last_d  = run_last;
          oi_d        = oi_q + DEC_CNT_W'(1);
          state_d     = run_last ? S_IDLE : S_ORD;
        end
      end
      S_DISC: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_valid_d  = 1'b1;
          out_status_d = 1'b1;
          out_last_d   = 1'b1;
          disc_d       = disc_q + TOTAL_W'(1);
          out_total_d  = disc_q + TOTAL_W'(1);
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // the byte two back enters the checksum, the newest two are the check
    if (emit_en) begin
      wr_d = wr_q + DEC_CNT_W'(1);
      h1_d = emit_val;
      h0_d = h1_q;
      if (wr_q >= DEC_CNT_W'(2)) begin
        lo_d = lo_sum;
        hi_d = add_mod(hi_q, lo_sum);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      ovr_q       <= 1'b0;
      len_q       <= '0;
      rd_q        <= '0;
      wr_q        <= '0;
      oi_q        <= '0;
      rem_q       <= '0;
      ff_q        <= 1'b0;
      disc_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      ovr_q       <= ovr_d;
      len_q       <= len_d;
      rd_q        <= rd_d;
      wr_q        <= wr_d;
      oi_q        <= oi_d;
      rem_q       <= rem_d;
      ff_q        <= ff_d;
      disc_q      <= disc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q <= lo_d;
    hi_q <= hi_d;
    h0_q <= h0_d;
    h1_q <= h1_d;
    if (out_load) begin
      out_status_q <= out_status_d;
      out_byte_q   <= out_byte_d;
      out_type_q   <= out_type_d;
      out_last_q   <= out_last_d;
      out_total_q  <= out_total_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (enc_we) begin
      enc_mem[cnt_q[ENC_IDX_W-1:0]] <= in_i.in_byte;
    end
    if (state_q == S_FETCH) begin
      enc_rd_q <= enc_mem[rd_q[ENC_IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_en) begin
      dec_mem[wr_q[DEC_IDX_W-1:0]] <= emit_val;
    end
    if (state_q == S_ORD) begin
      dec_rd_q <= dec_mem[oi_q[DEC_IDX_W-1:0]];
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.status        = out_status_q;
  assign out_o.out_byte      = out_byte_q;
  assign out_o.is_type       = out_type_q;
  assign out_o.last          = out_last_q;
  assign out_o.discard_total = out_total_q;

endmodule

`default_nettype wire

/* rtl/cfr_checker.sv */
// ----------------------------------------------------------------------------
// cfr_checker
// Port-level checks for the frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cfr_checker
  import cfr_pkg::*;
(
  input wire         clk_i,
  input wire         rst_ni,
  input wire         in_valid_i,
  input wire         in_ready_i,
  input wire         out_valid_i,
  input wire         out_ready_i,
  input wire         out_status_i,
  input wire byte_t  out_byte_i,
  input wire         out_is_type_i,
  input wire         out_last_i,
  input wire total_t out_total_i
);

  // stalled result keeps its contents
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_status_i) &&
      $stable(out_byte_i) && $stable(out_is_type_i) && $stable(out_last_i) &&
      $stable(out_total_i))
    else $error("result changed while stalled");

  // a discard result is a lone, empty, final transaction
  a_disc_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_status_i |-> out_byte_i == '0 && !out_is_type_i && out_last_i)
    else $error("malformed discard result");

  // no new byte is taken in the middle of a frame run
  a_run_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_last_i |-> !in_ready_i)
    else $error("input ready during a frame run");

  // a result never appears right after an input transaction
  a_no_quick_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !$rose(out_valid_i))
    else $error("result appeared one cycle after input");

endmodule

bind cobs_fletcher_frame_receiver_unit cfr_checker u_cfr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_status_i  (out_o.status),
  .out_byte_i    (out_o.out_byte),
  .out_is_type_i (out_o.is_type),
  .out_last_i    (out_o.last),
  .out_total_i   (out_o.discard_total)
);

`default_nettype wire

/* test/cobs_fletcher_frame_receiver_unit_tb.sv */
// ----------------------------------------------------------------------------
// cobs_fletcher_frame_receiver_unit_tb
// Drives COBS-encoded link bytes into the receiver and checks every decoded
// byte and discard result against a local frame predictor. Directed frames
// cover empty, short, malformed and bad-check frames; random frames mix good
// frames with corrupted, noisy, overrun and oversize ones under random stalls.
// ----------------------------------------------------------------------------
module cobs_fletcher_frame_receiver_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cfr_pkg::*;

  localparam int CLK_PERIOD     = 4;
  localparam int RESET_CYCLES   = 8;
  localparam int TARGET_BYTES   = 330;
  localparam int IDLE_PCT       = 17;
  localparam int CALM_FROM      = 120;
  localparam int CALM_TO        = 220;
  localparam int DRAIN_CYCLES   = 200;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int MAX_REPORTS    = 10;

  localparam logic STATUS_BYTE    = 1'b0;
  localparam logic STATUS_DISCARD = 1'b1;

  typedef byte_t byte_q_t[$];

  typedef struct packed {
    logic   status;
    byte_t  out_byte;
    logic   is_type;
    logic   last;
    total_t discard_total;
  } frame_result_t;

  typedef enum int {
    FK_GOOD,
    FK_BAD_CHECK,
    FK_NOISE,
    FK_SHORT,
    FK_EMPTY,
    FK_OVERRUN,
    FK_OVERFLOW
  } frame_kind_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic  drv_valid = 1'b0;
  byte_t drv_byte  = '0;
  logic  drv_ready = 1'b0;

  cfr_in_if  in_if ();
  cfr_out_if out_if ();

  assign in_if.valid   = drv_valid;
  assign in_if.in_byte = drv_byte;
  assign out_if.ready  = drv_ready;

  cobs_fletcher_frame_receiver_unit u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if.sink),
    .out_o  (out_if.source)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // predictor state
  byte_t                enc_buf [ENCODED_DEPTH];
  logic [ENC_CNT_W-1:0] enc_cnt     = '0;
  logic                 enc_overrun = 1'b0;
  total_t               discard_cnt = '0;

  byte_q_t       link_bytes;
  frame_result_t expected_results[$];

  int bytes_accepted  = 0;
  int results_checked = 0;
  int good_frames     = 0;
  int discard_frames  = 0;
  int mismatches      = 0;
  int quiet_cycles    = 0;

  wire calm = (bytes_accepted >= CALM_FROM) && (bytes_accepted < CALM_TO);

  function automatic logic [15:0] fletcher16(byte_q_t d, int n);
    int lo, hi;
    lo = 0;
    hi = 0;
    for (int i = 0; i < n; i++) begin
      lo = (lo + d[i]) % FLETCHER_MOD;
      hi = (hi + lo) % FLETCHER_MOD;
    end
    return {hi[7:0], lo[7:0]};
  endfunction

  // append the check bytes, low byte first
  function automatic byte_q_t seal(byte_q_t d);
    logic [15:0] sum;
    sum = fletcher16(d, d.size());
    d.push_back(sum[7:0]);
    d.push_back(sum[15:8]);
    return d;
  endfunction

  function automatic byte_q_t stuff_bytes(byte_q_t d);
    byte_q_t e;
    int      code_at;
    int      run;
    e.push_back(8'h00);
    code_at = 0;
    run     = 1;
    foreach (d[i]) begin
      if (d[i] == 8'h00) begin
        e[code_at] = byte_t'(run);
        code_at    = e.size();
        e.push_back(8'h00);
        run = 1;
      end else begin
        e.push_back(d[i]);
        run++;
      end
    end
    e[code_at] = byte_t'(run);
    return e;
  endfunction

  function automatic byte_q_t rand_bytes(int n, bit allow_zero);
    byte_q_t d;
    for (int i = 0; i < n; i++) begin
      if (!allow_zero) d.push_back(byte_t'($urandom_range(1, 255)));
      else if ($urandom_range(99) < 25) d.push_back(8'h00);
      else d.push_back(byte_t'($urandom_range(0, 255)));
    end
    return d;
  endfunction

  // walk the stored frame; 0 on a malformed code or an oversize result
  function automatic bit cobs_unstuff(output byte_q_t dec);
    int rd;
    int code;
    rd = 0;
    dec.delete();
    while (rd < enc_cnt) begin
      code = enc_buf[rd];
      rd++;
      for (int k = 1; k < code; k++) begin
        if (rd >= enc_cnt || dec.size() >= DEC_DEPTH) return 1'b0;
        dec.push_back(enc_buf[rd]);
        rd++;
      end
      if (code != CODE_NO_ZERO && rd < enc_cnt) begin
        if (dec.size() >= DEC_DEPTH) return 1'b0;
        dec.push_back(8'h00);
      end
    end
    return 1'b1;
  endfunction

  task automatic absorb_link_byte(input byte_t b);
    byte_q_t     dec;
    logic [15:0] sum;
    bit          good;
    bit          had_data;
    int          body;
    good = 1'b0;
    if (b != 8'h00) begin
      if (enc_cnt >= ENCODED_DEPTH) enc_overrun = 1'b1;
      else begin
        enc_buf[enc_cnt] = b;
        enc_cnt++;
      end
    end else begin
      had_data = enc_overrun || (enc_cnt != 0);
      if (!enc_overrun && enc_cnt != 0) begin
        if (cobs_unstuff(dec) && dec.size() >= CHK_MIN) begin
          sum  = fletcher16(dec, dec.size() - 2);
          good = (sum[7:0] == dec[dec.size() - 2]) && (sum[15:8] == dec[dec.size() - 1]);
        end
      end
      enc_cnt     = '0;
      enc_overrun = 1'b0;
      if (good) begin
        body = dec.size() - 2;
        for (int i = 0; i < body; i++)
          expected_results.push_back('{STATUS_BYTE, dec[i], i == 0, i == body - 1,
                                       discard_cnt});
        good_frames++;
      end else if (had_data) begin
        discard_cnt++;
        expected_results.push_back('{STATUS_DISCARD, 8'h00, 1'b0, 1'b1, discard_cnt});
        discard_frames++;
      end
    end
  endtask

  task automatic queue_encoded(input byte_q_t enc);
    foreach (enc[i]) link_bytes.push_back(enc[i]);
    link_bytes.push_back(8'h00);
  endtask

  task automatic queue_frame(input frame_kind_e kind, input int payload_len);
    byte_q_t d;
    byte_q_t enc;
    case (kind)
      FK_GOOD, FK_BAD_CHECK: begin
        d = seal(rand_bytes(1 + payload_len, 1'b1));
        if (kind == FK_BAD_CHECK)
          d[$urandom_range(d.size() - 1)] ^= byte_t'($urandom_range(1, 255));
        enc = stuff_bytes(d);
      end
      FK_NOISE:    enc = rand_bytes($urandom_range(1, 12), 1'b0);
      FK_SHORT:    enc = stuff_bytes(rand_bytes($urandom_range(1, 2), 1'b1));
      FK_OVERRUN:  enc = rand_bytes(ENCODED_DEPTH + $urandom_range(1, 4), 1'b0);
      FK_OVERFLOW: enc = stuff_bytes(rand_bytes(DEC_DEPTH + $urandom_range(1, 4), 1'b1));
      default: ;
    endcase
    queue_encoded(enc);
  endtask

  function automatic frame_kind_e pick_kind();
    int roll;
    roll = $urandom_range(99);
    if (roll < 58) return FK_GOOD;
    if (roll < 70) return FK_BAD_CHECK;
    if (roll < 80) return FK_NOISE;
    if (roll < 86) return FK_SHORT;
    if (roll < 91) return FK_EMPTY;
    if (roll < 96) return FK_OVERRUN;
    return FK_OVERFLOW;
  endfunction

  function automatic int pick_payload_len();
    if ($urandom_range(99) < 80) return $urandom_range(0, 6);
    return $urandom_range(7, MAX_PAYLOAD);
  endfunction

  // link byte driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      drv_valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        absorb_link_byte(in_if.in_byte);
        bytes_accepted++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (link_bytes.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          drv_valid <= 1'b1;
          drv_byte  <= link_bytes.pop_front();
        end else begin
          drv_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin : result_monitor
    frame_result_t want;
    frame_result_t got;
    if (!rst_ni) begin
      drv_ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        got = '{out_if.status, out_if.out_byte, out_if.is_type, out_if.last,
                out_if.discard_total};
        want = '0;
        if (expected_results.size() == 0 || got !== expected_results[0]) begin
          if (expected_results.size() != 0) want = expected_results[0];
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            if (expected_results.size() == 0)
              $display("result %0d: nothing expected", results_checked);
            else
              $display("result %0d: expected status=%0b byte=%02h type=%0b last=%0b total=%0d",
                       results_checked, want.status, want.out_byte, want.is_type,
                       want.last, want.discard_total);
            $display("result %0d:      got status=%0b byte=%02h type=%0b last=%0b total=%0d",
                     results_checked, got.status, got.out_byte, got.is_type, got.last,
                     got.discard_total);
          end
        end
        if (expected_results.size() != 0) void'(expected_results.pop_front());
        results_checked++;
      end
      drv_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // no transaction on either side for too long means the block is stuck
  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: %0d results still pending", expected_results.size());
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    byte_q_t d;
    int      frame_no;

    // directed frames
    link_bytes.push_back(8'h00);                      // empty frame
    queue_encoded(stuff_bytes(seal('{8'hFF})));       // type only, no payload
    queue_encoded(stuff_bytes(seal('{8'h00, 8'hFF, 8'h00})));
    queue_encoded('{8'h01, 8'h01});                   // decodes to a single byte
    queue_encoded('{8'h05, 8'h07});                   // code runs past the end
    d = seal('{8'h42, 8'h10});
    d[d.size() - 1] ^= 8'h01;                         // bad check byte
    queue_encoded(stuff_bytes(d));

    // random frames, the long corner cases first
    frame_no = 0;
    while (link_bytes.size() < TARGET_BYTES) begin
      case (frame_no)
        0:       queue_frame(FK_GOOD, MAX_PAYLOAD);
        1:       queue_frame(FK_OVERRUN, 0);
        2:       queue_frame(FK_OVERFLOW, 0);
        default: queue_frame(pick_kind(), pick_payload_len());
      endcase
      frame_no++;
    end

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (link_bytes.size() != 0 || drv_valid || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("sent %0d link bytes: %0d good frames and %0d discarded frames predicted",
             bytes_accepted, good_frames, discard_frames);
    $display("checked %0d results, %0d mismatches", results_checked, mismatches);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
